[hw/rtl/afpe_pkg.sv]
// Shared types, constants and codes for the fade and pan envelope block.
`default_nettype none

package afpe_pkg;

	// Widths of samples and frame counts
	localparam int SAMPLE_BITS = 16;
	localparam int FRAME_BITS  = 30;
	localparam int PROD_BITS   = SAMPLE_BITS + FRAME_BITS;
	localparam int STEP_BITS   = $clog2(SAMPLE_BITS);
	localparam int LANES       = 2;
	localparam int LANE_LEFT   = 0;
	localparam int LANE_RIGHT  = 1;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_EFFECT_MODE   = 2'd0;
	localparam logic [1:0] REG_STEREO        = 2'd1;
	localparam logic [1:0] REG_EFFECT_FRAMES = 2'd2;
	localparam logic [1:0] REG_TOTAL_FRAMES  = 2'd3;

	// Effect codes
	localparam logic [1:0] MODE_FADE_IN  = 2'd0;
	localparam logic [1:0] MODE_FADE_OUT = 2'd1;
	localparam logic [1:0] MODE_PAN      = 2'd2;

	// What the back end does with one channel of a frame
	typedef enum logic [1:0] {
		ACT_PASS  = 2'd0,
		ACT_ZERO  = 2'd1,
		ACT_SCALE = 2'd2
	} act_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_left;
		logic signed [SAMPLE_BITS-1:0] sample_right;
		logic                          clip_end;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} out_word_t;

	// Classified frame handed from front end to back end
	typedef struct packed {
		logic [LANES-1:0][SAMPLE_BITS-1:0] sample;
		act_t [LANES-1:0]                  act;
		logic [LANES-1:0][FRAME_BITS-1:0]  k;
		logic [FRAME_BITS-1:0]             n;
	} cmd_t;

	// Handshake between queue and back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_port_t;

endpackage

`default_nettype wire

[hw/rtl/afpe_front.sv]
// Front end: configuration registers, frame counter and per-frame classification.
`default_nettype none

module afpe_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [afpe_pkg::FRAME_BITS-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire afpe_pkg::in_word_t              in_word,
	output logic                                 push,
	output afpe_pkg::cmd_t                       push_cmd,
	input  wire logic                            queue_full
);
	import afpe_pkg::*;

	logic [1:0]            mode_q;
	logic                  stereo_q;
	logic [FRAME_BITS-1:0] effect_frames_q;
	logic [FRAME_BITS-1:0] total_frames_q;
	logic [FRAME_BITS-1:0] ramp_q;
	logic [FRAME_BITS-1:0] frame_q;

	logic                  f_lt_n;
	logic [FRAME_BITS-1:0] k_pan;
	logic [FRAME_BITS:0]   k_out_w;
	logic                  out_hit;

	// Hold configuration; keep the ramp length as min(effect, total) at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_FADE_IN;
			stereo_q        <= 1'b1;
			effect_frames_q <= '0;
			total_frames_q  <= '0;
			ramp_q          <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_EFFECT_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				REG_STEREO: begin
					stereo_q <= cfg_data[0];
				end
				REG_EFFECT_FRAMES: begin
					effect_frames_q <= cfg_data;
					ramp_q <= (cfg_data < total_frames_q) ? cfg_data : total_frames_q;
				end
				REG_TOTAL_FRAMES: begin
					total_frames_q <= cfg_data;
					ramp_q <= (effect_frames_q < cfg_data) ? effect_frames_q : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// Advance the frame counter, restart after the last frame of a clip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (push) begin
			frame_q <= in_word.clip_end ? '0 : frame_q + FRAME_BITS'(1);
		end
	end

	// Classify the frame: gain numerator per channel, or pass, or zero
	always_comb begin
		f_lt_n  = frame_q < ramp_q;
		k_pan   = ramp_q - frame_q - FRAME_BITS'(1);
		k_out_w = {1'b0, total_frames_q} - {1'b0, frame_q} - (FRAME_BITS+1)'(1);
		out_hit = !k_out_w[FRAME_BITS] && (k_out_w[FRAME_BITS-1:0] < ramp_q);

		push_cmd                    = '0;
		push_cmd.sample[LANE_LEFT]  = in_word.sample_left;
		push_cmd.sample[LANE_RIGHT] = in_word.sample_right;
		push_cmd.act[LANE_LEFT]     = ACT_PASS;
		push_cmd.act[LANE_RIGHT]    = ACT_PASS;
		push_cmd.n                  = ramp_q;

		unique case (mode_q)
			MODE_FADE_IN: begin
				if (f_lt_n) begin
					push_cmd.act[LANE_LEFT]  = ACT_SCALE;
					push_cmd.k[LANE_LEFT]    = frame_q;
					push_cmd.k[LANE_RIGHT]   = frame_q;
					if (stereo_q) begin
						push_cmd.act[LANE_RIGHT] = ACT_SCALE;
					end
				end
			end
			MODE_FADE_OUT: begin
				if (out_hit) begin
					push_cmd.act[LANE_LEFT]  = ACT_SCALE;
					push_cmd.k[LANE_LEFT]    = k_out_w[FRAME_BITS-1:0];
					push_cmd.k[LANE_RIGHT]   = k_out_w[FRAME_BITS-1:0];
					if (stereo_q) begin
						push_cmd.act[LANE_RIGHT] = ACT_SCALE;
					end
				end
			end
			MODE_PAN: begin
				if (stereo_q) begin
					if (f_lt_n) begin
						push_cmd.act[LANE_LEFT]  = ACT_SCALE;
						push_cmd.act[LANE_RIGHT] = ACT_SCALE;
						push_cmd.k[LANE_LEFT]    = k_pan;
						push_cmd.k[LANE_RIGHT]   = frame_q;
					end else begin
						push_cmd.act[LANE_LEFT]  = ACT_ZERO;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/afpe_queue.sv]
// Two-entry command queue between front end and back end.
`default_nettype none

module afpe_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire afpe_pkg::cmd_t      push_cmd,
	output logic                     full,
	output afpe_pkg::cmd_port_t      head,
	input  wire logic                pop
);
	import afpe_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head.valid = count_q != 2'd0;
	assign head.cmd   = entry_q[rd_ptr_q];

	// Write entry data
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/afpe_back.sv]
// Back end: multiply and restoring divide per channel, then the output register.
`default_nettype none

module afpe_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire afpe_pkg::cmd_port_t head,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output afpe_pkg::out_word_t      out_word
);
	import afpe_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_MUL  = 4'b0010,
		B_DIV  = 4'b0100,
		B_PUT  = 4'b1000
	} bstate_t;

	bstate_t               state_q;
	cmd_t                  cmd_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [FRAME_BITS-1:0] rem_q [LANES];
	logic [SAMPLE_BITS-1:0] lo_q [LANES];
	logic [LANES-1:0]      neg_q;
	logic                  out_valid_q;
	out_word_t             out_word_q;

	logic [SAMPLE_BITS-1:0] mag     [LANES];
	logic [PROD_BITS-1:0]   prod    [LANES];
	logic [FRAME_BITS:0]    trial   [LANES];
	logic [LANES-1:0]       fits;
	logic [SAMPLE_BITS-1:0] result  [LANES];
	logic                   load_out;

	assign pop      = (state_q == B_IDLE) && head.valid;
	assign load_out = (state_q == B_PUT) && (!out_valid_q || out_ready);

	// Magnitudes, products, division trial and final sign per lane
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i]   = cmd_q.sample[i][SAMPLE_BITS-1] ? (~cmd_q.sample[i] + SAMPLE_BITS'(1))
				: cmd_q.sample[i];
			prod[i]  = PROD_BITS'(mag[i]) * PROD_BITS'(cmd_q.k[i]);
			trial[i] = {rem_q[i], lo_q[i][SAMPLE_BITS-1]};
			fits[i]  = trial[i] >= {1'b0, cmd_q.n};
			unique case (cmd_q.act[i])
				ACT_SCALE: result[i] = neg_q[i] ? (~lo_q[i] + SAMPLE_BITS'(1)) : lo_q[i];
				ACT_ZERO:  result[i] = '0;
				default:   result[i] = cmd_q.sample[i];
			endcase
		end
	end

	// Sequence one frame: take, multiply, divide, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (head.valid) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					step_q  <= STEP_BITS'(SAMPLE_BITS - 1);
					state_q <= B_DIV;
				end
				B_DIV: begin
					step_q <= step_q - STEP_BITS'(1);
					if (step_q == '0) begin
						state_q <= B_PUT;
					end
				end
				B_PUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: command, remainder and quotient per lane
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		for (int i = 0; i < LANES; i++) begin
			if (state_q == B_MUL) begin
				rem_q[i] <= prod[i][PROD_BITS-1:SAMPLE_BITS];
				lo_q[i]  <= prod[i][SAMPLE_BITS-1:0];
				neg_q[i] <= cmd_q.sample[i][SAMPLE_BITS-1];
			end else if (state_q == B_DIV) begin
				if (fits[i]) begin
					rem_q[i] <= FRAME_BITS'(trial[i] - {1'b0, cmd_q.n});
					lo_q[i]  <= {lo_q[i][SAMPLE_BITS-2:0], 1'b1};
				end else begin
					rem_q[i] <= trial[i][FRAME_BITS-1:0];
					lo_q[i]  <= {lo_q[i][SAMPLE_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Hold the finished word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q.out_left  <= result[LANE_LEFT];
			out_word_q.out_right <= result[LANE_RIGHT];
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

[hw/rtl/audio_fade_pan_envelope.sv]
// Top level of the linear fade-in, fade-out and pan envelope.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  cfg      | cfg_write              | cfg_index (2 b), cfg_data (30 b)
//  in       | in_valid / in_ready    | in_word: sample_left, sample_right, clip_end
//  out      | out_valid / out_ready  | out_word: out_left, out_right
//
// Each frame passes through the back end in order: take a command, do the multiply,
// run one divider step per quotient bit, then load the output register. The back end
// takes a new command only once the last word is loaded into the output register.
// The front end accepts up to two frames ahead into its queue while the back end works.
// Reset clears all control state and restores register reset values; no clearing pass.
// A stalled output holds its word and the back end waits; the queue then fills and
// in_ready drops.
`default_nettype none

module audio_fade_pan_envelope (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [afpe_pkg::FRAME_BITS-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire afpe_pkg::in_word_t              in_word,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output afpe_pkg::out_word_t                  out_word
);
	import afpe_pkg::*;

	logic      push;
	cmd_t      push_cmd;
	logic      queue_full;
	cmd_port_t head;
	logic      pop;

	afpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	afpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.head     (head),
		.pop      (pop)
	);

	afpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

[hw/rtl/afpe_checker.sv]
// Port-level checker for the envelope block and its bind.
`default_nettype none

module afpe_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire afpe_pkg::out_word_t out_word
);
	import afpe_pkg::*;

	logic [2:0] inflight_q;

	// Track words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	// Hold the output idle through reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// Every delivered word belongs to an accepted one
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("output word without accepted input");

	// Queue, back end and output register hold at most four words
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd4 |-> !in_ready)
		else $error("input taken beyond capacity");

endmodule

bind audio_fade_pan_envelope afpe_checker u_afpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire
